// ===== rtl/co2rd_pkg.sv =====
`default_nettype none

package co2rd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // status word bits that flag a pending measurement
  localparam logic [15:0] STATUS_READY_MASK = 16'h07FF;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_MEAS   = 1'b1;

  localparam logic RES_OK      = 1'b0;
  localparam logic RES_CRC_ERR = 1'b1;

  // index of the closing word, and the word count that marks a frame as done
  localparam logic [1:0] LAST_WORD_STATUS = 2'd0;
  localparam logic [1:0] LAST_WORD_MEAS   = 2'd2;
  localparam logic [1:0] DONE_WORD_STATUS = 2'd1;
  localparam logic [1:0] DONE_WORD_MEAS   = 2'd3;

  // scale factors: centidegrees span, offset, centipercent span
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  typedef enum logic [1:0] {
    SLOT_HI  = 2'd0,
    SLOT_LO  = 2'd1,
    SLOT_CRC = 2'd2
  } byte_slot_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/co2rd_scale.sv =====
`default_nettype none

module co2rd_scale (
  input  wire logic        [15:0] temp_raw,
  input  wire logic        [15:0] hum_raw,
  output logic signed      [14:0] temperature_centi,
  output logic             [13:0] humidity_centi
);
  import co2rd_pkg::*;

  // floor(x / 65535) = q + (q + r >= 65535) with x = q * 65536 + r
  logic [30:0] temp_prod;
  logic [14:0] temp_q;
  logic [16:0] temp_sum;
  logic [14:0] temp_floor;
  logic [29:0] hum_prod;
  logic [13:0] hum_q;
  logic [16:0] hum_sum;

  always_comb begin
    temp_prod  = 31'(TEMP_SCALE) * 31'(temp_raw);
    temp_q     = temp_prod[30:16];
    temp_sum   = 17'(temp_q) + 17'(temp_prod[15:0]);
    temp_floor = temp_q + 15'(temp_sum >= FULL_SCALE);
    temperature_centi = $signed(temp_floor - TEMP_OFFSET);

    hum_prod = 30'(HUM_SCALE) * 30'(hum_raw);
    hum_q    = hum_prod[29:16];
    hum_sum  = 17'(hum_q) + 17'(hum_prod[15:0]);
    humidity_centi = hum_q + 14'(hum_sum >= FULL_SCALE);
  end

endmodule

`default_nettype wire

// ===== rtl/co2_sensor_response_decoder_core.sv =====
`default_nettype none

// a frame's result reaches the out_ ports after the input transaction of its last byte,
// passing through the input register, then the result register
// throughput: one byte per cycle; bytes keep flowing while a finished result waits,
// only the next frame's last byte holds in the input register until that result is taken
// reset (rst_n low, synchronous): pipeline emptied, decoder back at word 0
// with crc 0xFF and a status frame assumed
module co2_sensor_response_decoder_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_cmd,
  input  wire logic               in_frame_start,
  input  wire logic        [7:0]  in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_result_code,
  output logic             [1:0]  out_bad_word,
  output logic                    out_data_ready,
  output logic             [15:0] out_co2_ppm,
  output logic signed      [14:0] out_temperature_centi,
  output logic             [13:0] out_humidity_centi,
  output logic                    out_kind_out
);
  import co2rd_pkg::*;

  // input register
  logic       s1_valid_r;
  logic       s1_cmd_r;
  logic       s1_start_r;
  logic [7:0] s1_byte_r;

  // decoder state
  byte_slot_t slot_r, slot_nxt;
  logic [1:0]  word_r, word_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  high_r, high_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [15:0] co2_r, co2_nxt;
  logic [15:0] temp_r, temp_nxt;
  logic        err_r, err_nxt;
  logic [1:0]  bad_r, bad_nxt;
  logic        kind_r, kind_nxt;

  // result register
  logic        out_valid_r;
  logic        res_code_r;
  logic [1:0]  res_bad_r;
  logic        res_ready_r;
  logic [15:0] res_co2_r;
  logic signed [14:0] res_temp_r;
  logic [13:0] res_hum_r;
  logic        res_kind_r;

  // per-byte view once a frame start has been applied
  byte_slot_t  slot_eff;
  logic [1:0]  word_eff;
  logic [7:0]  crc_eff;
  logic        err_eff;
  logic [1:0]  bad_eff;
  logic        kind_eff;
  logic        active;
  logic        emits;
  logic        s1_go;
  logic        in_take;
  logic        out_take;

  logic signed [14:0] temp_scaled;
  logic [13:0]        hum_scaled;

  co2rd_scale u_scale (
    .temp_raw          (temp_r),
    .hum_raw           ({high_r, low_r}),
    .temperature_centi (temp_scaled),
    .humidity_centi    (hum_scaled)
  );

  always_comb begin
    if (s1_start_r) begin
      slot_eff = SLOT_HI;
      word_eff = 2'd0;
      crc_eff  = CRC_INIT;
      err_eff  = 1'b0;
      bad_eff  = 2'd0;
      kind_eff = s1_cmd_r;
    end else begin
      slot_eff = slot_r;
      word_eff = word_r;
      crc_eff  = crc_r;
      err_eff  = err_r;
      bad_eff  = bad_r;
      kind_eff = kind_r;
    end

    active = (kind_eff == KIND_MEAS) ? (word_eff != DONE_WORD_MEAS)
                                     : (word_eff != DONE_WORD_STATUS);

    slot_nxt = slot_eff;
    word_nxt = word_eff;
    crc_nxt  = crc_eff;
    high_nxt = high_r;
    low_nxt  = low_r;
    co2_nxt  = co2_r;
    temp_nxt = temp_r;
    err_nxt  = err_eff;
    bad_nxt  = bad_eff;
    kind_nxt = kind_eff;
    emits    = 1'b0;

    if (active) begin
      case (slot_eff)
        SLOT_HI: begin
          crc_nxt  = crc8_byte(CRC_INIT, s1_byte_r);
          high_nxt = s1_byte_r;
          slot_nxt = SLOT_LO;
        end
        SLOT_LO: begin
          crc_nxt  = crc8_byte(crc_eff, s1_byte_r);
          low_nxt  = s1_byte_r;
          slot_nxt = SLOT_CRC;
          if (word_eff == 2'd0) begin
            co2_nxt = {high_r, s1_byte_r};
          end else if (word_eff == 2'd1) begin
            temp_nxt = {high_r, s1_byte_r};
          end
        end
        SLOT_CRC: begin
          if (crc_eff != s1_byte_r && !err_eff) begin
            err_nxt = 1'b1;
            bad_nxt = word_eff;
          end
          slot_nxt = SLOT_HI;
          word_nxt = word_eff + 2'd1;
          emits = (kind_eff == KIND_MEAS) ? (word_eff == LAST_WORD_MEAS)
                                          : (word_eff == LAST_WORD_STATUS);
        end
        default: begin
          slot_nxt = SLOT_HI;
        end
      endcase
    end
  end

  assign s1_go    = s1_valid_r && (!emits || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r   <= in_cmd;
      s1_start_r <= in_frame_start;
      s1_byte_r  <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= SLOT_HI;
      word_r <= 2'd0;
      crc_r  <= CRC_INIT;
      high_r <= 8'd0;
      low_r  <= 8'd0;
      co2_r  <= 16'd0;
      temp_r <= 16'd0;
      err_r  <= 1'b0;
      bad_r  <= 2'd0;
      kind_r <= KIND_STATUS;
    end else if (s1_go) begin
      slot_r <= slot_nxt;
      word_r <= word_nxt;
      crc_r  <= crc_nxt;
      high_r <= high_nxt;
      low_r  <= low_nxt;
      co2_r  <= co2_nxt;
      temp_r <= temp_nxt;
      err_r  <= err_nxt;
      bad_r  <= bad_nxt;
      kind_r <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && emits) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  // on a crc error every measured field reads as zero
  always_ff @(posedge clk) begin
    if (s1_go && emits) begin
      res_code_r  <= err_nxt ? RES_CRC_ERR : RES_OK;
      res_bad_r   <= err_nxt ? bad_nxt : 2'd0;
      res_kind_r  <= kind_eff;
      res_ready_r <= !err_nxt && kind_eff == KIND_STATUS
                     && (({high_r, low_r} & STATUS_READY_MASK) != 16'd0);
      if (!err_nxt && kind_eff == KIND_MEAS) begin
        res_co2_r  <= co2_r;
        res_temp_r <= temp_scaled;
        res_hum_r  <= hum_scaled;
      end else begin
        res_co2_r  <= 16'd0;
        res_temp_r <= 15'sd0;
        res_hum_r  <= 14'd0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_result_code       = res_code_r;
  assign out_bad_word          = res_bad_r;
  assign out_data_ready        = res_ready_r;
  assign out_co2_ppm           = res_co2_r;
  assign out_temperature_centi = res_temp_r;
  assign out_humidity_centi    = res_hum_r;
  assign out_kind_out          = res_kind_r;

endmodule

`default_nettype wire

// ===== test/co2rd_reply_checker.sv =====
`timescale 1ns / 1ps

module co2rd_reply_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_cmd,
  input  logic               in_frame_start,
  input  logic        [7:0]  in_rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_result_code,
  input  logic        [1:0]  out_bad_word,
  input  logic               out_data_ready,
  input  logic        [15:0] out_co2_ppm,
  input  logic signed [14:0] out_temperature_centi,
  input  logic        [13:0] out_humidity_centi,
  input  logic               out_kind_out,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen,
  output int                 crc_error_results
);
  import co2rd_pkg::*;

  localparam logic [3:0] STATUS_BYTES = 4'd3;
  localparam logic [3:0] MEAS_BYTES   = 4'd9;

  typedef struct packed {
    logic        code;
    logic [1:0]  bad;
    logic        ready;
    logic [15:0] co2;
    logic [14:0] temp;
    logic [13:0] hum;
    logic        kind;
  } frame_result_t;

  frame_result_t results_due[$];

  // decoder state
  logic [3:0]  slot_pos;
  logic [7:0]  word_crc;
  logic [7:0]  hi_hold;
  logic [7:0]  lo_hold;
  logic [15:0] co2_word;
  logic [15:0] temp_word;
  logic        crc_bad_seen;
  logic [1:0]  bad_index;
  logic        frame_kind;

  // msb-first, one data bit per step
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ data[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  task automatic decode_reply_byte(input logic cmd, input logic fs, input logic [7:0] b);
    logic [3:0]  frame_len;
    logic [1:0]  word_idx;
    byte_slot_t  slot;
    logic [15:0] last_word;
    logic [31:0] t_scaled;
    logic [31:0] h_scaled;
    frame_result_t r;
    if (fs) begin
      slot_pos     = '0;
      word_crc     = CRC_INIT;
      crc_bad_seen = 1'b0;
      bad_index    = '0;
      frame_kind   = cmd;
    end
    frame_len = (frame_kind == KIND_MEAS) ? MEAS_BYTES : STATUS_BYTES;
    // bytes past the end of the frame are dropped silently
    if (slot_pos >= frame_len) return;
    word_idx = 2'(slot_pos / 3);
    slot     = byte_slot_t'(2'(slot_pos % 3));
    slot_pos = slot_pos + 4'd1;
    case (slot)
      SLOT_HI: begin
        word_crc = crc8_update(CRC_INIT, b);
        hi_hold  = b;
      end
      SLOT_LO: begin
        word_crc = crc8_update(word_crc, b);
        lo_hold  = b;
        if (word_idx == 2'd0) co2_word = {hi_hold, b};
        else if (word_idx == 2'd1) temp_word = {hi_hold, b};
      end
      default: begin
        if (word_crc != b && !crc_bad_seen) begin
          crc_bad_seen = 1'b1;
          bad_index    = word_idx;
        end
        if (slot_pos == frame_len) begin
          r      = '0;
          r.code = crc_bad_seen ? RES_CRC_ERR : RES_OK;
          r.bad  = crc_bad_seen ? bad_index : 2'd0;
          r.kind = frame_kind;
          if (!crc_bad_seen) begin
            last_word = {hi_hold, lo_hold};
            if (frame_kind == KIND_STATUS) begin
              r.ready = (last_word & STATUS_READY_MASK) != 16'd0;
            end else begin
              r.co2    = co2_word;
              t_scaled = (32'd17500 * {16'd0, temp_word}) / 32'd65535;
              r.temp   = 15'(t_scaled - 32'd4500);
              h_scaled = (32'd10000 * {16'd0, last_word}) / 32'd65535;
              r.hum    = h_scaled[13:0];
            end
          end
          results_due.push_back(r);
        end
      end
    endcase
  endtask

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      slot_pos          = '0;
      word_crc          = CRC_INIT;
      hi_hold           = '0;
      lo_hold           = '0;
      co2_word          = '0;
      temp_word         = '0;
      crc_bad_seen      = 1'b0;
      bad_index         = '0;
      frame_kind        = KIND_STATUS;
      fail_count        = 0;
      results_seen      = 0;
      crc_error_results = 0;
      results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_result_code == RES_CRC_ERR) crc_error_results++;
        if (results_due.size() == 0) begin
          $display("%0t ns: result transaction with none expected (code %0d kind %0d)",
                   $time, out_result_code, out_kind_out);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          compare_field("result_code", want.code, out_result_code);
          compare_field("bad_word", want.bad, out_bad_word);
          compare_field("data_ready", want.ready, out_data_ready);
          compare_field("co2_ppm", want.co2, out_co2_ppm);
          compare_field("temperature_centi", int'($signed(want.temp)),
                        int'(out_temperature_centi));
          compare_field("humidity_centi", want.hum, out_humidity_centi);
          compare_field("kind_out", want.kind, out_kind_out);
        end
      end
      if (in_valid && !in_stall) decode_reply_byte(in_cmd, in_frame_start, in_rx_byte);
    end
    pending = results_due.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import co2rd_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_cmd = 1'b0;
  logic               in_frame_start = 1'b0;
  logic        [7:0]  in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_result_code;
  logic        [1:0]  out_bad_word;
  logic               out_data_ready;
  logic        [15:0] out_co2_ppm;
  logic signed [14:0] out_temperature_centi;
  logic        [13:0] out_humidity_centi;
  logic               out_kind_out;

  int fail_count;
  int pending;
  int results_seen;
  int crc_error_results;

  int bytes_sent = 0;
  int bytes_ignored = 0;
  int frames_sent = 0;
  logic steady_in = 1'b0;
  logic steady_out = 1'b0;
  int stall_left = 0;

  always #2 clk = ~clk;

  co2_sensor_response_decoder_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_cmd                (in_cmd),
    .in_frame_start        (in_frame_start),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_result_code       (out_result_code),
    .out_bad_word          (out_bad_word),
    .out_data_ready        (out_data_ready),
    .out_co2_ppm           (out_co2_ppm),
    .out_temperature_centi (out_temperature_centi),
    .out_humidity_centi    (out_humidity_centi),
    .out_kind_out          (out_kind_out)
  );

  co2rd_reply_checker reply_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_cmd                (in_cmd),
    .in_frame_start        (in_frame_start),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_result_code       (out_result_code),
    .out_bad_word          (out_bad_word),
    .out_data_ready        (out_data_ready),
    .out_co2_ppm           (out_co2_ppm),
    .out_temperature_centi (out_temperature_centi),
    .out_humidity_centi    (out_humidity_centi),
    .out_kind_out          (out_kind_out),
    .fail_count            (fail_count),
    .pending               (pending),
    .results_seen          (results_seen),
    .crc_error_results     (crc_error_results)
  );

  // result side back-pressure: bursts of stall, mostly short, with quiet stretches
  always @(posedge clk) begin
    int roll;
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 5) steady_out = ~steady_out;
      if (steady_out) begin
        out_stall  <= 1'b0;
        stall_left = $urandom_range(20, 80);
      end else if (roll < 50) begin
        out_stall  <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else if (roll < 90) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(8, 30);
      end
    end
  end

  task automatic send_byte(input logic cmd, input logic fs, input logic [7:0] b);
    int gap;
    int roll;
    gap = 0;
    if (!steady_in) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(4, 24);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_frame_start <= fs;
    in_rx_byte     <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // one data word with its crc byte; cmd only matters on a frame-start byte
  task automatic send_word(input logic fs, input logic kind, input logic [15:0] w,
                           input logic corrupt);
    logic [7:0] crc;
    logic [7:0] flip;
    crc  = crc8_byte(crc8_byte(CRC_INIT, w[15:8]), w[7:0]);
    flip = corrupt ? 8'($urandom_range(1, 255)) : 8'h00;
    send_byte(fs ? kind : 1'($urandom), fs, w[15:8]);
    send_byte(1'($urandom), 1'b0, w[7:0]);
    send_byte(1'($urandom), 1'b0, crc ^ flip);
  endtask

  task automatic send_frame(input logic fs, input logic kind, input logic [15:0] w0,
                            input logic [15:0] w1, input logic [15:0] w2,
                            input logic [2:0] corrupt);
    send_word(fs, kind, w0, corrupt[0]);
    if (kind == KIND_MEAS) begin
      send_word(1'b0, kind, w1, corrupt[1]);
      send_word(1'b0, kind, w2, corrupt[2]);
    end
    frames_sent++;
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001 << $urandom_range(0, 15);
      3: return {5'($urandom), 11'h000};
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic       kind;
    logic [2:0] corrupt;
    int         roll;
    int         n;
    int         waited;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // status frame right after reset with no frame start
    send_frame(1'b0, KIND_STATUS, 16'h0000, 16'h0, 16'h0, 3'b000);
    // ready flag from bit 10 alone, then upper bits only with a bad crc
    send_frame(1'b1, KIND_STATUS, 16'h0400, 16'h0, 16'h0, 3'b000);
    send_frame(1'b1, KIND_STATUS, 16'hF800, 16'h0, 16'h0, 3'b001);
    // full-scale measurement, then one trailing byte that must be ignored
    send_frame(1'b1, KIND_MEAS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000);
    send_byte(1'b1, 1'b0, 8'hA5);
    bytes_ignored++;
    // partial measurement, dropped by the next frame start
    send_byte(KIND_MEAS, 1'b1, 8'h00);
    send_byte(1'b0, 1'b0, 8'hFF);
    send_frame(1'b1, KIND_MEAS, 16'h0000, 16'h0000, 16'h0000, 3'b000);

    while (bytes_sent < 1050) begin
      if ($urandom_range(0, 19) == 0) steady_in = ~steady_in;
      roll = $urandom_range(0, 99);
      kind = 1'($urandom);
      if (roll < 80) begin
        corrupt = {$urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                   $urandom_range(0, 7) == 0};
        send_frame(1'b1, kind, pick_word(), pick_word(), pick_word(), corrupt);
        if ($urandom_range(0, 99) < 30) begin
          n = $urandom_range(1, 3);
          repeat (n) send_byte(1'($urandom), 1'b0, 8'($urandom));
          bytes_ignored += n;
        end
      end else if (roll < 90) begin
        // truncated frame, the next frame start abandons it
        n = $urandom_range(1, (kind == KIND_MEAS) ? 8 : 2);
        send_byte(kind, 1'b1, 8'($urandom));
        repeat (n - 1) send_byte(1'($urandom), 1'b0, 8'($urandom));
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(1'($urandom), $urandom_range(0, 3) == 0, 8'($urandom));
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);

    $display("sent %0d reply bytes (%0d past frame end) in %0d complete frames",
             bytes_sent, bytes_ignored, frames_sent);
    $display("checked %0d frame results, %0d of them flagged crc errors",
             results_seen, crc_error_results);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      if (pending != 0) $display("%0d expected results never arrived", pending);
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
